FILE: hdl/ple_pkg.sv
`timescale 1ns / 1ps
// ple_pkg: field widths, operation codes and status codes of the positional list engine
// no dependencies; used by the channel interfaces, the core and its checker

package ple_pkg;

  localparam int OP_W     = 3;
  localparam int VALUE_W  = 3;
  localparam int POS_W    = 6;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 6;

  // a dump gives at most this many beats
  localparam int MAX_RESULTS = 32;

  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_INSERT     = 3'd1;
  localparam logic [OP_W-1:0] OP_REMOVE     = 3'd2;
  localparam logic [OP_W-1:0] OP_CLEAR      = 3'd3;
  localparam logic [OP_W-1:0] OP_DUMP       = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OOB   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

endpackage

FILE: hdl/ple_ifs.sv
`timescale 1ns / 1ps
// ple_cmd_if and ple_rsp_if: valid/ready channels of the positional list engine
// depends on ple_pkg for the field widths

interface ple_cmd_if;
  logic                         valid;
  logic                         ready;
  logic [ple_pkg::OP_W-1:0]     operation;
  logic [ple_pkg::VALUE_W-1:0]  value;
  logic [ple_pkg::POS_W-1:0]    position;

  modport source (output valid, output operation, output value, output position,
                  input ready);
  modport sink   (input valid, input operation, input value, input position,
                  output ready);
endinterface

interface ple_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [ple_pkg::STATUS_W-1:0]  status;
  logic [ple_pkg::VALUE_W-1:0]   item_value;
  logic [ple_pkg::COUNT_W-1:0]   count;
  logic                          is_ordered;
  logic                          last;

  modport source (output valid, output status, output item_value, output count,
                  output is_ordered, output last, input ready);
  modport sink   (input valid, input status, input item_value, input count,
                  input is_ordered, input last, output ready);
endinterface

FILE: hdl/positional_list_engine_core.sv
`timescale 1ns / 1ps
// positional_list_engine_core: ordered list of small values kept in one slot memory
// depends on ple_pkg and the channel interfaces in ple_ifs.sv

// The list lives in a CAPACITY-entry slot memory with one write port and one registered read
// port, so every shift goes through it one entry per cycle. A command is taken only while
// the engine is idle. An insert shifts the values from position p up by one slot and a
// remove shifts those behind p down by one; each is followed by an order scan over the
// values left in the list that stops at the first descent, and then the result is posted.
// Clear, errors and unknown codes go straight to the result. A dump reads one slot per
// beat, at most 32 beats. The result register lets the next command in while the last
// beat still waits to be taken.

module positional_list_engine_core #(
  parameter int CAPACITY = 32
) (
  input  logic           clk,
  input  logic           rst,
  ple_cmd_if.sink        cmd,
  ple_rsp_if.source      rsp
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = ((CW > ple_pkg::POS_W) ? CW : ple_pkg::POS_W) + 1;

  typedef enum logic [3:0] {
    IDLE, REM_ITEM, MOVE, INS_PUT, SCAN_RD, SCAN_CMP, RESP, DUMP_RD, DUMP_OUT
  } state_t;

  state_t                          state;
  logic [CW-1:0]                   cnt;
  logic                            ordered;
  logic [AW-1:0]                   wptr;
  logic [AW-1:0]                   sptr;
  logic [AW-1:0]                   dptr;
  logic [AW-1:0]                   dend;
  logic [AW-1:0]                   pos_r;
  logic [ple_pkg::VALUE_W-1:0]     val_r;
  logic                            dir_up;
  logic [ple_pkg::VALUE_W-1:0]     prev;
  logic [ple_pkg::STATUS_W-1:0]    res_status;
  logic [ple_pkg::VALUE_W-1:0]     res_item;

  logic                            out_valid;
  logic [ple_pkg::STATUS_W-1:0]    out_status;
  logic [ple_pkg::VALUE_W-1:0]     out_item;
  logic [ple_pkg::COUNT_W-1:0]     out_count;
  logic                            out_ordered;
  logic                            out_last;

  logic [ple_pkg::VALUE_W-1:0]     mem [CAPACITY];
  logic [ple_pkg::VALUE_W-1:0]     rd;
  logic [AW-1:0]                   ra;
  logic                            we;
  logic [AW-1:0]                   wa;
  logic [ple_pkg::VALUE_W-1:0]     wd;

  logic                            accept;
  logic                            out_free;
  logic [XW-1:0]                   cnt_x;
  logic [XW-1:0]                   pos_x;
  logic [XW-1:0]                   ins_x;
  logic [AW-1:0]                   ins_idx;
  logic                            full;

  assign accept   = cmd.valid && (state == IDLE);
  assign out_free = !out_valid || rsp.ready;
  assign cnt_x    = XW'(cnt);
  assign pos_x    = XW'(cmd.position);
  // push front is an insert at position zero
  assign ins_x    = (cmd.operation == ple_pkg::OP_PUSH_FRONT) ? '0 : pos_x;
  assign ins_idx  = AW'(ins_x);
  assign full     = cnt_x >= XW'(CAPACITY);

  assign cmd.ready      = (state == IDLE);
  assign rsp.valid      = out_valid;
  assign rsp.status     = out_status;
  assign rsp.item_value = out_item;
  assign rsp.count      = out_count;
  assign rsp.is_ordered = out_ordered;
  assign rsp.last       = out_last;

  // memory address and write control
  always_comb begin
    ra = dptr;
    we = 1'b0;
    wa = wptr;
    wd = rd;
    case (state)
      IDLE: begin
        if (cmd.operation == ple_pkg::OP_REMOVE) begin
          ra = AW'(cmd.position);
        end else begin
          ra = AW'(cnt - CW'(1));
        end
      end
      REM_ITEM: ra = AW'(pos_r + AW'(1));
      MOVE: begin
        we = 1'b1;
        ra = dir_up ? AW'(wptr + AW'(2)) : AW'(wptr - AW'(2));
      end
      INS_PUT: begin
        we = 1'b1;
        wa = pos_r;
        wd = val_r;
      end
      SCAN_RD, SCAN_CMP: ra = sptr;
      default: ra = dptr;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd <= mem[ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      cnt       <= '0;
      ordered   <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (accept) begin
            res_status <= ple_pkg::ST_OK;
            res_item   <= '0;
            state      <= RESP;
            case (cmd.operation)
              ple_pkg::OP_PUSH_FRONT, ple_pkg::OP_INSERT: begin
                if (cmd.operation == ple_pkg::OP_INSERT && pos_x > cnt_x) begin
                  res_status <= ple_pkg::ST_OOB;
                end else if (full) begin
                  res_status <= ple_pkg::ST_FULL;
                end else begin
                  pos_r <= ins_idx;
                  val_r <= cmd.value;
                  if (ins_x == cnt_x) begin
                    state <= INS_PUT;
                  end else begin
                    wptr   <= AW'(cnt);
                    dir_up <= 1'b0;
                    state  <= MOVE;
                  end
                end
              end
              ple_pkg::OP_REMOVE: begin
                if (cnt == '0) begin
                  res_status <= ple_pkg::ST_EMPTY;
                end else if (pos_x >= cnt_x) begin
                  res_status <= ple_pkg::ST_OOB;
                end else begin
                  pos_r <= AW'(cmd.position);
                  state <= REM_ITEM;
                end
              end
              ple_pkg::OP_CLEAR: begin
                if (cnt == '0) begin
                  res_status <= ple_pkg::ST_EMPTY;
                end else begin
                  cnt     <= '0;
                  ordered <= 1'b1;
                end
              end
              ple_pkg::OP_DUMP: begin
                if (cnt == '0) begin
                  res_status <= ple_pkg::ST_EMPTY;
                end else begin
                  dptr  <= '0;
                  dend  <= (cnt_x > XW'(ple_pkg::MAX_RESULTS)) ?
                           AW'(ple_pkg::MAX_RESULTS - 1) : AW'(cnt - CW'(1));
                  state <= DUMP_RD;
                end
              end
              default: state <= RESP;
            endcase
          end
        end
        REM_ITEM: begin
          res_item <= rd;
          if (XW'(pos_r) + XW'(1) == cnt_x) begin
            cnt     <= cnt - CW'(1);
            sptr    <= '0;
            ordered <= 1'b1;
            state   <= SCAN_RD;
          end else begin
            wptr   <= pos_r;
            dir_up <= 1'b1;
            state  <= MOVE;
          end
        end
        MOVE: begin
          if (dir_up) begin
            if (XW'(wptr) + XW'(2) == cnt_x) begin
              cnt     <= cnt - CW'(1);
              sptr    <= '0;
              ordered <= 1'b1;
              state   <= SCAN_RD;
            end else begin
              wptr <= wptr + AW'(1);
            end
          end else begin
            if (XW'(wptr) == XW'(pos_r) + XW'(1)) begin
              state <= INS_PUT;
            end else begin
              wptr <= wptr - AW'(1);
            end
          end
        end
        INS_PUT: begin
          cnt     <= cnt + CW'(1);
          sptr    <= '0;
          ordered <= 1'b1;
          state   <= SCAN_RD;
        end
        SCAN_RD: begin
          if (cnt_x <= XW'(1)) begin
            state <= RESP;
          end else begin
            state <= SCAN_CMP;
          end
        end
        SCAN_CMP: begin
          // stop at the first descent
          if (sptr != '0 && prev > rd) begin
            ordered <= 1'b0;
            state   <= RESP;
          end else begin
            prev <= rd;
            if (XW'(sptr) + XW'(1) == cnt_x) begin
              state <= RESP;
            end else begin
              sptr  <= sptr + AW'(1);
              state <= SCAN_RD;
            end
          end
        end
        RESP: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            out_status  <= res_status;
            out_item    <= res_item;
            out_count   <= ple_pkg::COUNT_W'(cnt);
            out_ordered <= ordered;
            out_last    <= 1'b1;
            state       <= IDLE;
          end
        end
        DUMP_RD: state <= DUMP_OUT;
        DUMP_OUT: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            out_status  <= ple_pkg::ST_OK;
            out_item    <= rd;
            out_count   <= ple_pkg::COUNT_W'(cnt);
            out_ordered <= ordered;
            out_last    <= (dptr == dend);
            if (dptr == dend) begin
              state <= IDLE;
            end else begin
              dptr  <= dptr + AW'(1);
              state <= DUMP_RD;
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

FILE: hdl/ple_checker.sv
`timescale 1ns / 1ps
// ple_checker: port-level checks on the result channel of the list engine, bound to the core
// depends on ple_pkg and positional_list_engine_core

module ple_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          rsp_valid,
  input logic                          rsp_ready,
  input logic [ple_pkg::STATUS_W-1:0]  rsp_status,
  input logic [ple_pkg::VALUE_W-1:0]   rsp_item_value,
  input logic [ple_pkg::COUNT_W-1:0]   rsp_count,
  input logic                          rsp_is_ordered,
  input logic                          rsp_last
);

  // a stalled beat keeps its contents
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid &&
      $stable({rsp_status, rsp_item_value, rsp_count, rsp_is_ordered, rsp_last}))
    else $error("result beat changed while stalled");

  // an empty list reports no value and counts as ordered
  a_empty: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status == ple_pkg::ST_EMPTY |->
      rsp_count == '0 && rsp_item_value == '0 && rsp_is_ordered && rsp_last)
    else $error("empty status with stored values");

  // only a dump gives more than one beat; every beat but the last must be ok
  a_multi_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_last |-> rsp_status == ple_pkg::ST_OK)
    else $error("non-final beat with error status");

  a_err_item: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status == ple_pkg::ST_OOB || rsp_status == ple_pkg::ST_FULL) |->
      rsp_item_value == '0)
    else $error("rejected command reports a value");

endmodule

bind positional_list_engine_core ple_checker u_ple_checker (
  .clk            (clk),
  .rst            (rst),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .rsp_status     (rsp.status),
  .rsp_item_value (rsp.item_value),
  .rsp_count      (rsp.count),
  .rsp_is_ordered (rsp.is_ordered),
  .rsp_last       (rsp.last)
);

FILE: verif/positional_list_engine_core_test.sv
`timescale 1ns / 1ps
// positional_list_engine_core_test: self-checking bench for the positional list engine
// depends on ple_pkg, the channel interfaces in ple_ifs.sv and positional_list_engine_core

module positional_list_engine_core_test;

  typedef logic [ple_pkg::OP_W-1:0]    op_code_t;
  typedef logic [ple_pkg::VALUE_W-1:0] color_t;
  typedef logic [ple_pkg::POS_W-1:0]   pos_t;

  localparam int CLK_PERIOD    = 10;
  localparam int LIST_CAPACITY = 32;
  localparam int RANDOM_ITEMS  = 50;
  localparam int HOLD_OFF      = 300;
  localparam int SETTLE_CYCLES = 200;
  localparam longint TIMEOUT_NS = 5_000_000;

  // codes above dump are not decoded by the engine
  localparam int OP_FIRST_UNUSED = int'(ple_pkg::OP_DUMP) + 1;
  localparam int OP_LAST_CODE    = (1 << ple_pkg::OP_W) - 1;
  localparam int VALUE_TOP_COLOR = 4;
  localparam pos_t POS_MAX       = '1;

  typedef struct packed {
    logic [ple_pkg::STATUS_W-1:0] status;
    logic [ple_pkg::VALUE_W-1:0]  item_value;
    logic [ple_pkg::COUNT_W-1:0]  count;
    logic                         is_ordered;
    logic                         last;
  } list_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ple_cmd_if cmd_ch ();
  ple_rsp_if rsp_ch ();

  positional_list_engine_core #(
    .CAPACITY (LIST_CAPACITY)
  ) i_dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .rsp (rsp_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // shadow copy of the list
  color_t     list_vals [LIST_CAPACITY];
  int         list_len = 0;
  list_beat_t expected_beats [$];

  int error_count   = 0;
  bit cmd_gaps_on   = 1'b1;
  bit rsp_stalls_on = 1'b1;
  int hold_cycles   = 0;

  task automatic report_mismatch(input string msg);
    error_count++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  function automatic logic list_sorted();
    for (int k = 1; k < list_len; k++) begin
      if (list_vals[k-1] > list_vals[k]) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic add_expected_beat(input logic [ple_pkg::STATUS_W-1:0] status,
                                   input color_t item, input logic last);
    list_beat_t b;
    b.status     = status;
    b.item_value = item;
    b.count      = list_len[ple_pkg::COUNT_W-1:0];
    b.is_ordered = list_sorted();
    b.last       = last;
    expected_beats.push_back(b);
  endtask

  task automatic insert_value(input int at, input color_t val);
    for (int k = list_len; k > at; k--) list_vals[k] = list_vals[k-1];
    list_vals[at] = val;
    list_len++;
  endtask

  // updates the shadow list and queues the beats one command produces
  task automatic apply_list_op(input op_code_t op, input color_t val, input pos_t pos);
    color_t taken;
    int     n;
    case (op)
      ple_pkg::OP_PUSH_FRONT: begin
        if (list_len >= LIST_CAPACITY) begin
          add_expected_beat(ple_pkg::ST_FULL, '0, 1'b1);
        end else begin
          insert_value(0, val);
          add_expected_beat(ple_pkg::ST_OK, '0, 1'b1);
        end
      end
      ple_pkg::OP_INSERT: begin
        // bounds check wins over full
        if (int'(pos) > list_len) begin
          add_expected_beat(ple_pkg::ST_OOB, '0, 1'b1);
        end else if (list_len >= LIST_CAPACITY) begin
          add_expected_beat(ple_pkg::ST_FULL, '0, 1'b1);
        end else begin
          insert_value(int'(pos), val);
          add_expected_beat(ple_pkg::ST_OK, '0, 1'b1);
        end
      end
      ple_pkg::OP_REMOVE: begin
        if (list_len == 0) begin
          add_expected_beat(ple_pkg::ST_EMPTY, '0, 1'b1);
        end else if (int'(pos) >= list_len) begin
          add_expected_beat(ple_pkg::ST_OOB, '0, 1'b1);
        end else begin
          taken = list_vals[int'(pos)];
          for (int k = int'(pos); k + 1 < list_len; k++) list_vals[k] = list_vals[k+1];
          list_len--;
          add_expected_beat(ple_pkg::ST_OK, taken, 1'b1);
        end
      end
      ple_pkg::OP_CLEAR: begin
        if (list_len == 0) begin
          add_expected_beat(ple_pkg::ST_EMPTY, '0, 1'b1);
        end else begin
          list_len = 0;
          add_expected_beat(ple_pkg::ST_OK, '0, 1'b1);
        end
      end
      ple_pkg::OP_DUMP: begin
        if (list_len == 0) begin
          add_expected_beat(ple_pkg::ST_EMPTY, '0, 1'b1);
        end else begin
          n = (list_len < ple_pkg::MAX_RESULTS) ? list_len : ple_pkg::MAX_RESULTS;
          for (int k = 0; k < n; k++) begin
            add_expected_beat(ple_pkg::ST_OK, list_vals[k], k == n - 1);
          end
        end
      end
      default: add_expected_beat(ple_pkg::ST_OK, '0, 1'b1);
    endcase
  endtask

  // called at a rising edge; returns at the edge where the beat was taken
  task automatic send_list_op(input op_code_t op, input color_t val, input pos_t pos);
    int unsigned gap;
    gap = cmd_gaps_on ? $urandom_range(0, 14) : 0;
    if (gap != 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_ch.valid     <= 1'b1;
    cmd_ch.operation <= op;
    cmd_ch.value     <= val;
    cmd_ch.position  <= pos;
    do @(posedge clk); while (cmd_ch.ready !== 1'b1);
    apply_list_op(op, val, pos);
  endtask

  task automatic wait_for_results();
    cmd_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_beats.size() != 0);
  endtask

  task automatic test_empty_list();
    send_list_op(ple_pkg::OP_CLEAR, 3'd0, 6'd0);
    send_list_op(ple_pkg::OP_REMOVE, 3'd7, 6'd0);
    send_list_op(ple_pkg::OP_REMOVE, 3'd0, POS_MAX);
    send_list_op(ple_pkg::OP_DUMP, 3'd0, 6'd0);
    send_list_op(ple_pkg::OP_INSERT, 3'd1, 6'd1);
    for (int c = OP_FIRST_UNUSED; c <= OP_LAST_CODE; c++) begin
      send_list_op(op_code_t'(c), 3'd7, POS_MAX);
    end
    send_list_op(ple_pkg::OP_INSERT, 3'd7, 6'd0);
    send_list_op(ple_pkg::OP_DUMP, 3'd0, 6'd0);
  endtask

  task automatic test_push_insert();
    send_list_op(ple_pkg::OP_PUSH_FRONT, 3'd4, 6'd0);
    send_list_op(ple_pkg::OP_PUSH_FRONT, 3'd0, POS_MAX);
    // positions past the count are rejected as out of bounds
    send_list_op(ple_pkg::OP_INSERT, 3'd4, 6'd3);
    send_list_op(ple_pkg::OP_INSERT, 3'd2, 6'd5);
    send_list_op(ple_pkg::OP_INSERT, 3'd2, 6'd1);
    send_list_op(ple_pkg::OP_INSERT, 3'd5, POS_MAX);
    send_list_op(ple_pkg::OP_DUMP, 3'd0, 6'd0);
  endtask

  task automatic test_remove();
    send_list_op(ple_pkg::OP_REMOVE, 3'd0, 6'd0);
    send_list_op(ple_pkg::OP_REMOVE, 3'd0, pos_t'(list_len - 1));
    send_list_op(ple_pkg::OP_REMOVE, 3'd0, pos_t'(list_len));
    send_list_op(ple_pkg::OP_REMOVE, 3'd7, POS_MAX);
    send_list_op(ple_pkg::OP_DUMP, 3'd0, 6'd0);
    send_list_op(ple_pkg::OP_CLEAR, 3'd0, 6'd0);
    send_list_op(ple_pkg::OP_DUMP, 3'd0, 6'd0);
  endtask

  task automatic test_full_list();
    send_list_op(ple_pkg::OP_CLEAR, 3'd0, 6'd0);
    for (int i = 0; i < LIST_CAPACITY; i++) begin
      send_list_op(ple_pkg::OP_INSERT,
                   color_t'((i * (VALUE_TOP_COLOR + 1)) / LIST_CAPACITY), pos_t'(list_len));
    end
    send_list_op(ple_pkg::OP_PUSH_FRONT, 3'd0, 6'd0);
    send_list_op(ple_pkg::OP_INSERT, 3'd0, pos_t'(LIST_CAPACITY));
    send_list_op(ple_pkg::OP_INSERT, 3'd0, pos_t'(LIST_CAPACITY + 1));
    send_list_op(ple_pkg::OP_DUMP, 3'd0, 6'd0);
    send_list_op(ple_pkg::OP_REMOVE, 3'd0, pos_t'(LIST_CAPACITY - 1));
    send_list_op(ple_pkg::OP_PUSH_FRONT, 3'd7, 6'd0);
    send_list_op(ple_pkg::OP_DUMP, 3'd0, 6'd0);
  endtask

  task automatic test_backpressure();
    hold_cycles = HOLD_OFF;
    send_list_op(ple_pkg::OP_PUSH_FRONT, 3'd1, 6'd0);
    send_list_op(ple_pkg::OP_DUMP, 3'd0, 6'd0);
    send_list_op(ple_pkg::OP_REMOVE, 3'd0, 6'd2);
    send_list_op(ple_pkg::OP_INSERT, 3'd3, 6'd4);
    send_list_op(ple_pkg::OP_DUMP, 3'd0, 6'd0);
    send_list_op(op_code_t'(OP_FIRST_UNUSED), 3'd0, 6'd0);
    send_list_op(ple_pkg::OP_PUSH_FRONT, 3'd6, 6'd0);
    send_list_op(ple_pkg::OP_REMOVE, 3'd0, 6'd0);
    wait_for_results();
  endtask

  task automatic test_random_ops();
    int unsigned pick;
    op_code_t    op;
    color_t      val;
    pos_t        pos;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      // rotate idling: both sides, neither, sender only, receiver only
      case ((i / 12) % 4)
        0: begin cmd_gaps_on = 1'b1; rsp_stalls_on = 1'b1; end
        1: begin cmd_gaps_on = 1'b0; rsp_stalls_on = 1'b0; end
        2: begin cmd_gaps_on = 1'b1; rsp_stalls_on = 1'b0; end
        default: begin cmd_gaps_on = 1'b0; rsp_stalls_on = 1'b1; end
      endcase
      pick = $urandom_range(0, 99);
      if (pick < 22)      op = ple_pkg::OP_PUSH_FRONT;
      else if (pick < 50) op = ple_pkg::OP_INSERT;
      else if (pick < 74) op = ple_pkg::OP_REMOVE;
      else if (pick < 77) op = ple_pkg::OP_CLEAR;
      else if (pick < 90) op = ple_pkg::OP_DUMP;
      else                op = op_code_t'($urandom_range(OP_FIRST_UNUSED, OP_LAST_CODE));
      if ($urandom_range(0, 99) < 85) val = color_t'($urandom_range(0, VALUE_TOP_COLOR));
      else                            val = color_t'($urandom_range(VALUE_TOP_COLOR + 1, 7));
      pos = pos_t'($urandom_range(0, POS_MAX));
      if ($urandom_range(0, 99) < 80) begin
        if (op == ple_pkg::OP_INSERT) begin
          pos = pos_t'($urandom_range(0, list_len));
        end else if (op == ple_pkg::OP_REMOVE && list_len > 0) begin
          pos = pos_t'($urandom_range(0, list_len - 1));
        end
      end
      send_list_op(op, val, pos);
    end
    cmd_gaps_on   = 1'b1;
    rsp_stalls_on = 1'b1;
  endtask

  initial begin : result_sink
    int unsigned stall;
    rsp_ch.ready <= 1'b0;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      stall = rsp_stalls_on ? $urandom_range(0, 14) : 0;
      if (hold_cycles != 0) begin
        stall       = hold_cycles;
        hold_cycles = 0;
      end
      if (stall != 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (rsp_ch.valid !== 1'b1);
    end
  end

  always @(posedge clk) begin : beat_check
    list_beat_t want;
    if (rst === 1'b0 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      if (expected_beats.size() == 0) begin
        report_mismatch("result beat with nothing expected");
      end else begin
        want = expected_beats.pop_front();
        if (rsp_ch.status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", rsp_ch.status, want.status));
        if (rsp_ch.item_value !== want.item_value)
          report_mismatch($sformatf("item_value %0d, want %0d", rsp_ch.item_value,
                                    want.item_value));
        if (rsp_ch.count !== want.count)
          report_mismatch($sformatf("count %0d, want %0d", rsp_ch.count, want.count));
        if (rsp_ch.is_ordered !== want.is_ordered)
          report_mismatch($sformatf("is_ordered %0b, want %0b", rsp_ch.is_ordered,
                                    want.is_ordered));
        if (rsp_ch.last !== want.last)
          report_mismatch($sformatf("last %0b, want %0b", rsp_ch.last, want.last));
      end
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    cmd_ch.valid     <= 1'b0;
    cmd_ch.operation <= ple_pkg::OP_PUSH_FRONT;
    cmd_ch.value     <= '0;
    cmd_ch.position  <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_empty_list();
    test_push_insert();
    test_remove();
    test_full_list();
    test_backpressure();
    test_random_ops();
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
